@@ sv/tactile_tile_normalizer_macros.svh @@
`ifndef TACTILE_TILE_NORMALIZER_MACROS_SVH
`define TACTILE_TILE_NORMALIZER_MACROS_SVH
// assertion helpers for the tactile tile normalizer checker
// both expect clock and reset in the scope where they are used

// consequent checked in the same cycle as the antecedent
`define TTN_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tactile_tile_normalizer check failed");

// consequent checked in the cycle after the antecedent
`define TTN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tactile_tile_normalizer check failed");

`endif

@@ sv/ttn_pkg.sv @@
// ----------------------------------------------------------------------------
// ttn_pkg
// Types, region shape tables and canvas layout for the tactile tile normalizer.
// ----------------------------------------------------------------------------
package ttn_pkg;

   localparam int SHAPE_COUNT  = 17;
   localparam int GROUP_COUNT  = 6;
   localparam int TILE_COLUMNS = 4;
   localparam int TILE_WIDTH   = 8;
   localparam int TILE_HEIGHT  = 14;
   localparam int TILE_GAP     = 1;
   localparam int CANVAS_WIDTH = TILE_COLUMNS * TILE_WIDTH + (TILE_COLUMNS - 1) * TILE_GAP;
   localparam int POS_W        = 11;
   localparam int ROW_W        = 4;
   localparam int COL_W        = 4;
   localparam int DIV_STEPS    = 8;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_PIXEL = 2'd1;
   localparam logic [1:0] FUNC_GROUP = 2'd2;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef struct packed {
      logic [1:0]         func;
      logic [4:0]         region_or_group;
      logic [6:0]         taxel_index;
      logic signed [15:0] taxel_value;
   } req_type;

   typedef struct packed {
      logic [11:0] canvas_address;
      logic [7:0]  intensity;
      logic [14:0] peak_value;
      logic        status;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [14:0] rem_init;
      logic [7:0]  bits;
      logic [14:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [7:0]  quotient;
      logic [14:0] remainder;
   } div_rsp_type;

   function automatic logic [3:0] shape_rows(input logic [4:0] r);
      logic [3:0] rows;
      case (r)
         5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd14: rows = 4'd3;
         5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd15: rows = 4'd12;
         5'd2, 5'd5, 5'd8, 5'd11: rows = 4'd10;
         5'd16: rows = 4'd14;
         default: rows = 4'd0;
      endcase
      return rows;
   endfunction

   function automatic logic [3:0] shape_cols(input logic [4:0] r);
      logic [3:0] cols;
      case (r) inside
         5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd14: cols = 4'd3;
         [5'd0:5'd16]: cols = 4'd8;
         default: cols = 4'd0;
      endcase
      return cols;
   endfunction

   function automatic logic [2:0] shape_group(input logic [4:0] r);
      logic [2:0] g;
      case (r) inside
         [5'd0:5'd2]:   g = 3'd0;
         [5'd3:5'd5]:   g = 3'd1;
         [5'd6:5'd8]:   g = 3'd2;
         [5'd9:5'd11]:  g = 3'd3;
         [5'd12:5'd15]: g = 3'd4;
         5'd16:         g = 3'd5;
         default:       g = 3'd7;
      endcase
      return g;
   endfunction

   function automatic logic [6:0] shape_size(input logic [4:0] r);
      logic [7:0] p;
      p = {4'd0, shape_rows(r)} * {4'd0, shape_cols(r)};
      return p[6:0];
   endfunction

   // first store entry of each region, regions packed back to back
   function automatic logic [POS_W-1:0] shape_base(input logic [4:0] r);
      logic [POS_W-1:0] b;
      case (r)
         5'd0:    b = 11'd0;
         5'd1:    b = 11'd9;
         5'd2:    b = 11'd105;
         5'd3:    b = 11'd185;
         5'd4:    b = 11'd194;
         5'd5:    b = 11'd290;
         5'd6:    b = 11'd370;
         5'd7:    b = 11'd379;
         5'd8:    b = 11'd475;
         5'd9:    b = 11'd555;
         5'd10:   b = 11'd564;
         5'd11:   b = 11'd660;
         5'd12:   b = 11'd740;
         5'd13:   b = 11'd749;
         5'd14:   b = 11'd845;
         5'd15:   b = 11'd854;
         5'd16:   b = 11'd950;
         default: b = 11'd1062;
      endcase
      return b;
   endfunction

   // canvas address of a region's first taxel, region centred in its tile
   function automatic logic [11:0] tile_origin(input logic [4:0] r);
      logic [4:0]  tr;
      logic [4:0]  tc;
      logic [3:0]  rows;
      logic [3:0]  cols;
      logic [15:0] xo;
      logic [15:0] yo;
      logic [15:0] org;
      tr   = 5'(r / TILE_COLUMNS);
      tc   = 5'(r % TILE_COLUMNS);
      rows = shape_rows(r);
      cols = shape_cols(r);
      xo   = 16'(int'(tc) * (TILE_WIDTH + TILE_GAP));
      yo   = 16'(int'(tr) * (TILE_HEIGHT + TILE_GAP));
      if (int'(cols) <= TILE_WIDTH) begin
         xo = xo + 16'((TILE_WIDTH - int'(cols)) / 2);
      end
      if (int'(rows) <= TILE_HEIGHT) begin
         yo = yo + 16'((TILE_HEIGHT - int'(rows)) / 2);
      end
      org = 16'(int'(yo) * CANVAS_WIDTH + int'(xo));
      return org[11:0];
   endfunction

endpackage

@@ sv/ttn_ram.sv @@
// ----------------------------------------------------------------------------
// ttn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ttn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1062
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ttn_divider.sv @@
// ----------------------------------------------------------------------------
// ttn_divider
// Shared restoring divider, one quotient bit per cycle, eight bits per run.
// ----------------------------------------------------------------------------
module ttn_divider
   import ttn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [14:0]      rem_ff, rem_in;
   logic [14:0]      div_ff, div_in;
   logic [7:0]       quo_ff, quo_in;
   logic [15:0]      shifted;
   logic [16:0]      trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[7]};
      trial   = {1'b0, shifted} - {2'b00, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = cmd.rem_init;
         div_in  = cmd.divisor;
         quo_in  = cmd.bits;
      end else if (busy_ff) begin
         // dividend bits shift out the top as quotient bits shift in below
         if (!trial[16]) begin
            rem_in = trial[14:0];
            quo_in = {quo_ff[6:0], 1'b1};
         end else begin
            rem_in = shifted[14:0];
            quo_in = {quo_ff[6:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

@@ sv/tactile_tile_normalizer.sv @@
// ----------------------------------------------------------------------------
// tactile_tile_normalizer
// Writes give no result unless out of range, which returns a range status; group reads scan
// one region a cycle. Pixel reads use two 8-step runs of the shared divider, the second skipped
// when the intensity saturates or the pixel is dark. One transaction at a time: req_stall stays
// high until a result enters the output register or a write completes.
// Reset clears control state and region peaks at once; the taxel store is not cleared.
// ----------------------------------------------------------------------------
module tactile_tile_normalizer
   import ttn_pkg::*;
#(
   parameter int REGION_COUNT = 17
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int PEAK_DEPTH  = (REGION_COUNT < SHAPE_COUNT) ? REGION_COUNT : SHAPE_COUNT;
   localparam int PEAK_AW     = (PEAK_DEPTH > 1) ? $clog2(PEAK_DEPTH) : 1;
   localparam int STORE_DEPTH = int'(shape_base(5'(PEAK_DEPTH)));
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_ROWCOL = 3'd2;
   localparam logic [2:0] S_SCALE  = 3'd3;
   localparam logic [2:0] S_NORM   = 3'd4;
   localparam logic [2:0] S_GROUP  = 3'd5;
   localparam logic [2:0] S_RESULT = 3'd6;

   logic [2:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [4:0]       ptr_ff, ptr_in;
   logic [14:0]      best_ff, best_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic [14:0]      peak_ff [PEAK_DEPTH];

   logic             peak_wr_en;
   logic [14:0]      peak_wr_data;
   logic [4:0]       peak_rd_idx;
   logic [14:0]      peak_rd;
   logic [4:0]       sel;
   logic [6:0]       idx;
   logic             region_ok;
   logic [POS_W-1:0] pos;
   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [15:0]      ram_rd_data;
   div_cmd_type      div_cmd;
   div_rsp_type      div_rsp;
   logic [14:0]      peak_base;
   logic [15:0]      addr_sum;
   logic [22:0]      scaled;
   logic [14:0]      best_next;
   logic             rsp_load;

   assign sel         = req_ff.region_or_group;
   assign idx         = req_ff.taxel_index;
   assign region_ok   = sel < 5'(PEAK_DEPTH);
   assign pos         = shape_base(sel) + {4'd0, idx};
   assign peak_rd_idx = (state_ff == S_GROUP) ? ptr_ff : sel;
   assign peak_rd     = (peak_rd_idx < 5'(PEAK_DEPTH)) ? peak_ff[peak_rd_idx[PEAK_AW-1:0]] : '0;
   assign rsp_load    = (state_ff == S_RESULT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      ptr_in       = ptr_ff;
      best_in      = best_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      res_in       = res_ff;
      peak_wr_en   = 1'b0;
      peak_wr_data = '0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      div_cmd      = '0;
      peak_base    = (idx == 7'd0) ? 15'd0 : peak_rd;
      addr_sum     = {4'd0, tile_origin(sel)} + 16'(int'(row_ff) * CANVAS_WIDTH)
                     + {12'd0, col_ff};
      scaled       = {ram_rd_data[14:0], 8'd0} - {8'd0, ram_rd_data[14:0]};
      best_next    = best_ff;
      if ((ptr_ff < 5'(PEAK_DEPTH)) && (shape_group(ptr_ff) == sel[2:0])
          && (peak_rd > best_ff)) begin
         best_next = peak_rd;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_in        = '0;
            res_in.status = STATUS_RANGE;
            state_in      = S_RESULT;
            case (req_ff.func)
               FUNC_GROUP: begin
                  if (sel < 5'(GROUP_COUNT)) begin
                     ptr_in   = '0;
                     best_in  = '0;
                     state_in = S_GROUP;
                  end
               end
               FUNC_WRITE, FUNC_PIXEL: begin
                  if (region_ok && (idx < shape_size(sel))) begin
                     if (req_ff.func == FUNC_WRITE) begin
                        // taxel 0 restarts the running peak, negatives never raise it
                        ram_wr_en    = 1'b1;
                        peak_wr_en   = 1'b1;
                        peak_wr_data = peak_base;
                        if (!req_ff.taxel_value[15]
                            && (req_ff.taxel_value[14:0] > peak_base)) begin
                           peak_wr_data = req_ff.taxel_value[14:0];
                        end
                        state_in = S_IDLE;
                     end else begin
                        ram_rd_en        = 1'b1;
                        div_cmd.start    = 1'b1;
                        div_cmd.rem_init = '0;
                        div_cmd.bits     = {1'b0, idx};
                        div_cmd.divisor  = {11'd0, shape_cols(sel)};
                        state_in         = S_ROWCOL;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_ROWCOL: begin
            if (div_rsp.done) begin
               row_in   = div_rsp.quotient[ROW_W-1:0];
               col_in   = div_rsp.remainder[COL_W-1:0];
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            res_in.canvas_address = addr_sum[11:0];
            res_in.peak_value     = peak_rd;
            res_in.status         = STATUS_OK;
            if ((peak_rd == 15'd0) || ram_rd_data[15]) begin
               res_in.intensity = 8'd0;
               state_in         = S_RESULT;
            end else if (scaled >= {peak_rd, 8'd0}) begin
               res_in.intensity = 8'd255;
               state_in         = S_RESULT;
            end else begin
               // quotient fits eight bits, so the high part already sits below the peak
               div_cmd.start    = 1'b1;
               div_cmd.rem_init = scaled[22:8];
               div_cmd.bits     = scaled[7:0];
               div_cmd.divisor  = peak_rd;
               state_in         = S_NORM;
            end
         end
         S_NORM: begin
            if (div_rsp.done) begin
               res_in.intensity = div_rsp.quotient;
               state_in         = S_RESULT;
            end
         end
         S_GROUP: begin
            best_in = best_next;
            ptr_in  = ptr_ff + 5'd1;
            if (ptr_ff == 5'(SHAPE_COUNT - 1)) begin
               res_in            = '0;
               res_in.peak_value = best_next;
               res_in.status     = STATUS_OK;
               state_in          = S_RESULT;
            end
         end
         S_RESULT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register parts the result side from the sequencer
   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_load ? res_ff : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PEAK_DEPTH; i++) begin
            peak_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (peak_wr_en) begin
            peak_ff[sel[PEAK_AW-1:0]] <= peak_wr_data;
         end
      end
      req_ff      <= req_in;
      ptr_ff      <= ptr_in;
      best_ff     <= best_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   ttn_ram #(
      .WIDTH(16),
      .DEPTH(STORE_DEPTH)
   ) u_taxel_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(pos[STORE_AW-1:0]),
      .wr_data(req_ff.taxel_value),
      .rd_en  (ram_rd_en),
      .rd_addr(pos[STORE_AW-1:0]),
      .rd_data(ram_rd_data)
   );

   ttn_divider u_divider (
      .clock(clock),
      .reset(reset),
      .cmd  (div_cmd),
      .rsp  (div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sv/ttn_checker.sv @@
// ----------------------------------------------------------------------------
// ttn_checker
// Port-level checks for the tactile tile normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "tactile_tile_normalizer_macros.svh"

module ttn_checker
   import ttn_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // one transaction at a time: the block stalls right after taking one
   `TTN_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   `TTN_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   `TTN_ASSERT_SAME(a_error_fields_zero, rsp_valid && rsp_data.status == STATUS_RANGE, rsp_data.canvas_address == 12'd0 && rsp_data.intensity == 8'd0 && rsp_data.peak_value == 15'd0)

   // no peak means nothing to scale against
   `TTN_ASSERT_SAME(a_zero_peak_dark, rsp_valid && rsp_data.status == STATUS_OK && rsp_data.peak_value == 15'd0, rsp_data.intensity == 8'd0)

endmodule

bind tactile_tile_normalizer ttn_checker u_ttn_checker (.*);
